[src/pmac_pkg.sv]
// Shared types and constants of the Poly1305 authenticator.
// Used by the front end, the back end and the top level; no dependencies.
package pmac_pkg;

	// Radix-2^26 limb representation of values mod 2^130-5
	localparam int NLIMB  = 5;
	localparam int LIMB_W = 26;

	// Clamp masks of r, one per 26-bit limb
	localparam logic [25:0] R_MASK0 = 26'h3ffffff;
	localparam logic [25:0] R_MASK1 = 26'h3ffff03;
	localparam logic [25:0] R_MASK2 = 26'h3ffc0ff;
	localparam logic [25:0] R_MASK3 = 26'h3f03fff;
	localparam logic [25:0] R_MASK4 = 26'h00fffff;

	// Configuration port geometry and register map
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam logic [1:0] REG_R_LO = 2'd0;
	localparam logic [1:0] REG_R_HI = 2'd1;
	localparam logic [1:0] REG_S_LO = 2'd2;
	localparam logic [1:0] REG_S_HI = 2'd3;

	// One-time key as held in the configuration registers
	typedef struct packed {
		logic [63:0] r_lo;
		logic [63:0] r_hi;
		logic [63:0] s_lo;
		logic [63:0] s_hi;
	} key_t;

	// Classified request passed from front end to back end
	typedef struct packed {
		logic         last;
		logic         absorb;
		logic [128:0] msg;
	} item_t;

endpackage

[src/pmac_fifo.sv]
// Small register queue with a combinational head read.
// Used between front and back end and as the result queue; no dependencies.
module pmac_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue occupancy did not grow on push");

endmodule

[src/pmac_front.sv]
// Front end: pads a message block to its 129-bit value and classifies it.
// Depends on pmac_pkg; feeds the request queue in front of pmac_back.
module pmac_front (
	input  logic                 push,
	output logic                 full,
	input  logic [63:0]          block_low,
	input  logic [63:0]          block_high,
	input  logic [4:0]           byte_count,
	input  logic                 last_block,
	output logic                 q_push,
	output pmac_pkg::item_t      q_item,
	input  logic                 q_full
);
	import pmac_pkg::*;

	logic [4:0]   cnt;
	logic [127:0] raw;
	logic [127:0] padded;

	// Saturate the count at a full block
	assign cnt = (byte_count > 5'd16) ? 5'd16 : byte_count;
	assign raw = {block_high, block_low};

	// Keep valid bytes, place the 0x01 pad byte, zero the rest
	always_comb begin
		for (int b = 0; b < 16; b++) begin
			if (5'(b) < cnt) begin
				padded[8*b +: 8] = raw[8*b +: 8];
			end else if (5'(b) == cnt) begin
				padded[8*b +: 8] = 8'h01;
			end else begin
				padded[8*b +: 8] = 8'h00;
			end
		end
	end

	// Full blocks carry bit 128; empty non-last items are dropped
	always_comb begin
		q_item.msg    = {(cnt == 5'd16), padded};
		q_item.absorb = (cnt != 5'd0);
		q_item.last   = last_block;
	end

	assign full   = q_full;
	assign q_push = push && !q_full && (q_item.absorb || last_block);

endmodule

[src/pmac_back.sv]
// Back end: multiply-accumulate h = (h + m) * r mod 2^130-5, final reduction
// and tag formation. Depends on pmac_pkg; drains the request queue.
module pmac_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pmac_pkg::key_t   key,
	input  pmac_pkg::item_t  q_item,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             out_push,
	output logic [127:0]     out_tag,
	input  logic             out_full
);
	import pmac_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAC  = 3'd1;
	localparam logic [2:0] ST_WRAP = 3'd2;
	localparam logic [2:0] ST_FIN1 = 3'd3;
	localparam logic [2:0] ST_FIN2 = 3'd4;
	localparam logic [2:0] ST_FIN3 = 3'd5;
	localparam logic [2:0] ST_FIN4 = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  col_q;
	logic        last_q;
	logic [26:0] h_q    [NLIMB];
	logic [27:0] hm_q   [NLIMB];
	logic [25:0] rl_q   [NLIMB];
	logic [28:0] s_q    [1:4];
	logic [56:0] prod_q [NLIMB];
	logic [31:0] carry_q;
	logic [1:0]  fc_q;

	logic [28:0]  coef [NLIMB];
	logic [127:0] rkey;
	logic [25:0]  rl_in [NLIMB];
	logic [25:0]  ml_in [NLIMB];
	logic [59:0]  dsum;
	logic [31:0]  wrap0;
	logic [27:0]  a [NLIMB];
	logic [27:0]  b [1:4];
	logic [27:0]  g [NLIMB];
	logic         g_sel;
	logic [129:0] packed_h;

	// Clamp r and split key and message into limbs
	assign rkey = {key.r_hi, key.r_lo};
	always_comb begin
		rl_in[0] = rkey[25:0]    & R_MASK0;
		rl_in[1] = rkey[51:26]   & R_MASK1;
		rl_in[2] = rkey[77:52]   & R_MASK2;
		rl_in[3] = rkey[103:78]  & R_MASK3;
		rl_in[4] = rkey[129-2:104+0] & 26'(R_MASK4);
		ml_in[0] = q_item.msg[25:0];
		ml_in[1] = q_item.msg[51:26];
		ml_in[2] = q_item.msg[77:52];
		ml_in[3] = q_item.msg[103:78];
		ml_in[4] = 26'(q_item.msg[128:104]);
	end

	// Pick the r or 5*r limb that multiplies limb i in the current column
	always_comb begin
		for (int i = 0; i < NLIMB; i++) begin
			coef[i] = '0;
			for (int k = 0; k < NLIMB; k++) begin
				if (col_q == 3'(k)) begin
					if (k >= i) begin
						coef[i] = 29'(rl_q[k - i]);
					end else begin
						coef[i] = s_q[k + NLIMB - i];
					end
				end
			end
		end
	end

	// Column sum with the carry from the previous column
	assign dsum = 60'(prod_q[0]) + 60'(prod_q[1]) + 60'(prod_q[2])
		+ 60'(prod_q[3]) + 60'(prod_q[4]) + 60'(carry_q);

	// Fold the top carry back into limb 0
	assign wrap0 = 32'(h_q[0]) + carry_q * 32'd5;

	// First carry round of the final reduction, wrapping into limb 0
	always_comb begin
		a[1] = 28'(h_q[1]);
		a[2] = 28'(h_q[2]) + 28'(a[1][27:26]);
		a[3] = 28'(h_q[3]) + 28'(a[2][27:26]);
		a[4] = 28'(h_q[4]) + 28'(a[3][27:26]);
		a[0] = 28'(h_q[0]) + 28'(a[4][27:26]) * 28'd5;
	end

	// Second carry round, no wrap at the top
	always_comb begin
		b[1] = 28'(h_q[1]) + 28'(fc_q);
		b[2] = 28'(h_q[2]) + 28'(b[1][27:26]);
		b[3] = 28'(h_q[3]) + 28'(b[2][27:26]);
		b[4] = 28'(h_q[4]) + 28'(b[3][27:26]);
	end

	// Trial subtraction of p: take h + 5 - 2^130 when it does not go negative
	always_comb begin
		g[0] = 28'(h_q[0]) + 28'd5;
		g[1] = 28'(h_q[1]) + 28'(g[0][27:26]);
		g[2] = 28'(h_q[2]) + 28'(g[1][27:26]);
		g[3] = 28'(h_q[3]) + 28'(g[2][27:26]);
		g[4] = 28'(h_q[4]) + 28'(g[3][27:26]);
		g_sel = |g[4][27:26];
	end

	assign packed_h = {h_q[4][25:0], h_q[3][25:0], h_q[2][25:0], h_q[1][25:0],
		h_q[0][25:0]};

	// Add s mod 2^128 and hand the tag to the result queue
	assign out_tag  = packed_h[127:0] + {key.s_hi, key.s_lo};
	assign out_push = (state_q == ST_FIN4) && !out_full;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	// Sequence absorb and finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			last_q  <= 1'b0;
			for (int i = 0; i < NLIMB; i++) begin
				h_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						last_q <= q_item.last;
						col_q  <= '0;
						if (q_item.absorb) begin
							state_q <= ST_MAC;
						end else begin
							state_q <= ST_FIN1;
						end
					end
				end
				ST_MAC: begin
					for (int j = 0; j < NLIMB; j++) begin
						if (col_q == 3'(j + 1)) begin
							h_q[j] <= {1'b0, dsum[25:0]};
						end
					end
					if (col_q == 3'(NLIMB)) begin
						state_q <= ST_WRAP;
					end else begin
						col_q <= col_q + 3'd1;
					end
				end
				ST_WRAP: begin
					h_q[0]  <= {1'b0, wrap0[25:0]};
					h_q[1]  <= h_q[1] + 27'(wrap0[31:26]);
					state_q <= last_q ? ST_FIN1 : ST_IDLE;
				end
				ST_FIN1: begin
					h_q[0]  <= {1'b0, a[0][25:0]};
					h_q[1]  <= {1'b0, a[1][25:0]};
					h_q[2]  <= {1'b0, a[2][25:0]};
					h_q[3]  <= {1'b0, a[3][25:0]};
					h_q[4]  <= {1'b0, a[4][25:0]};
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					h_q[1]  <= {1'b0, b[1][25:0]};
					h_q[2]  <= {1'b0, b[2][25:0]};
					h_q[3]  <= {1'b0, b[3][25:0]};
					h_q[4]  <= b[4][26:0];
					state_q <= ST_FIN3;
				end
				ST_FIN3: begin
					for (int i = 0; i < NLIMB; i++) begin
						h_q[i] <= {1'b0, g_sel ? g[i][25:0] : h_q[i][25:0]};
					end
					state_q <= ST_FIN4;
				end
				ST_FIN4: begin
					if (!out_full) begin
						for (int i = 0; i < NLIMB; i++) begin
							h_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: operands, products, carries
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !q_empty) begin
			for (int i = 0; i < NLIMB; i++) begin
				hm_q[i] <= 28'(h_q[i]) + 28'(ml_in[i]);
				rl_q[i] <= rl_in[i];
			end
			for (int i = 1; i < NLIMB; i++) begin
				s_q[i] <= {1'b0, rl_in[i], 2'b00} + 29'(rl_in[i]);
			end
			carry_q <= '0;
		end else if (state_q == ST_MAC) begin
			if (col_q < 3'(NLIMB)) begin
				for (int i = 0; i < NLIMB; i++) begin
					prod_q[i] <= hm_q[i] * coef[i];
				end
			end
			if (col_q != 3'd0) begin
				carry_q <= dsum[57:26];
			end
		end
		if (state_q == ST_FIN1) begin
			fc_q <= a[0][27:26];
		end
	end

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= 3'(NLIMB))
		else $error("column counter out of range");

	a_clear_after_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |=> (h_q[0] == '0 && h_q[4] == '0 && state_q == ST_IDLE))
		else $error("accumulator not cleared after tag");

	a_last_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRAP && last_q) |=> (state_q == ST_FIN1))
		else $error("last block did not enter final reduction");

endmodule

[src/poly1305_mac.sv]
// A full or partial block passes IDLE, MAC and WRAP in the multiply unit; a last
// block then passes the reduction states FIN1 to FIN4 (an empty last item goes
// from IDLE to FIN1), and its tag is pushed once the result queue has room. The
// shared five-multiplier column unit of h*r starts a block only when idle;
// input is taken every cycle while the request queue has room. Reset clears
// control, key registers and accumulator at once, with no clearing pass.
module poly1305_mac #(
	parameter int QUEUE_DEPTH  = 4,
	parameter int RESULT_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pmac_pkg::ADDR_W-1:0] paddr,
	input  logic [pmac_pkg::DATA_W-1:0] pwdata,
	output logic [pmac_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [63:0]                 block_low,
	input  logic [63:0]                 block_high,
	input  logic [4:0]                  byte_count,
	input  logic                        last_block,
	output logic                        empty,
	input  logic                        pop,
	output logic [63:0]                 tag_low,
	output logic [63:0]                 tag_high
);
	import pmac_pkg::*;

	key_t         key_q;
	logic         q_push, q_full, q_pop, q_empty;
	item_t        q_wr, q_rd;
	logic         out_push, out_full;
	logic [127:0] out_tag, out_head;
	logic [1:0]   reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];

	// Write key registers on the access phase of a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_R_LO: key_q.r_lo <= pwdata;
				REG_R_HI: key_q.r_hi <= pwdata;
				REG_S_LO: key_q.s_lo <= pwdata;
				REG_S_HI: key_q.s_hi <= pwdata;
				default:  key_q <= key_q;
			endcase
		end
	end

	// Read back the addressed key register
	always_comb begin
		case (reg_idx)
			REG_R_LO: prdata = key_q.r_lo;
			REG_R_HI: prdata = key_q.r_hi;
			REG_S_LO: prdata = key_q.s_lo;
			REG_S_HI: prdata = key_q.s_hi;
			default:  prdata = '0;
		endcase
	end

	pmac_front u_front (
		.push       (push),
		.full       (full),
		.block_low  (block_low),
		.block_high (block_high),
		.byte_count (byte_count),
		.last_block (last_block),
		.q_push     (q_push),
		.q_item     (q_wr),
		.q_full     (q_full)
	);

	pmac_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_req_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty)
	);

	pmac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_q),
		.q_item   (q_rd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.out_push (out_push),
		.out_tag  (out_tag),
		.out_full (out_full)
	);

	pmac_fifo #(
		.WIDTH (128),
		.DEPTH (RESULT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.wr_data (out_tag),
		.full    (out_full),
		.pop     (pop),
		.rd_data (out_head),
		.empty   (empty)
	);

	assign tag_low  = out_head[63:0];
	assign tag_high = out_head[127:64];

endmodule

[tb/poly1305_mac_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the Poly1305 authenticator poly1305_mac.
// Depends on pmac_pkg for the register map; predicts each tag with wide arithmetic.
module poly1305_mac_tb;
	import pmac_pkg::*;

	localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
	localparam logic [263:0] PRIME = (264'd1 << 130) - 264'd5;
	localparam int PHASE_ITEMS = 330;
	localparam int SETTLE_CYCLES = 80;

	// Tag predictor: keeps the key, the accumulator reduced mod 2^130-5 and the tags owed
	class poly1305_tag_calc;
		logic [63:0]  key[4];
		logic [129:0] acc;
		logic [127:0] tags_due[$];
		int           errors;
		int           tags_seen;
		int           blocks_absorbed;

		function new();
			foreach (key[i]) key[i] = '0;
			acc = '0;
			errors = 0;
			tags_seen = 0;
			blocks_absorbed = 0;
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("%s", what);
		endfunction

		function void set_key(logic [1:0] idx, logic [63:0] val);
			key[idx] = val;
		endfunction

		// Pad the block, fold it into h and queue the tag on a last request
		function void absorb_request(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt,
				logic last);
			int           n;
			logic [127:0] data;
			logic [127:0] keep;
			logic [128:0] msg;
			logic [127:0] r;
			logic [263:0] wide;
			logic [127:0] t;
			n = (cnt > 5'd16) ? 16 : int'(cnt);
			data = {hi, lo};
			if (n != 0) begin
				if (n == 16) begin
					msg = {1'b1, data};
				end else begin
					keep = (128'd1 << (8 * n)) - 128'd1;
					msg = {1'b0, data & keep} | (129'd1 << (8 * n));
				end
				r = {key[REG_R_HI], key[REG_R_LO]} & R_CLAMP;
				wide = 264'(acc) + 264'(msg);
				wide = wide * 264'(r);
				acc = 130'(wide % PRIME);
				blocks_absorbed++;
			end
			if (last) begin
				t = acc[127:0] + {key[REG_S_HI], key[REG_S_LO]};
				tags_due.push_back(t);
				acc = '0;
			end
		endfunction

		// Compare one popped tag with the oldest one owed
		function void check_tag(logic [63:0] lo, logic [63:0] hi);
			logic [127:0] want;
			tags_seen++;
			if (tags_due.size() == 0) begin
				flag($sformatf("unexpected tag %h_%h at %0t", hi, lo, $time));
			end else begin
				want = tags_due.pop_front();
				if (lo !== want[63:0] || hi !== want[127:64])
					flag($sformatf("tag mismatch at %0t: low exp %h got %h, high exp %h got %h",
						$time, want[63:0], lo, want[127:64], hi));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic [63:0] block_low = '0;
	logic [63:0] block_high = '0;
	logic [4:0]  byte_count = '0;
	logic        last_block = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [63:0] tag_low;
	logic [63:0] tag_high;

	poly1305_tag_calc tag_calc = new();
	int items_sent = 0;
	int key_settings = 0;
	bit quiet = 1'b0;
	bit tx_calm = 1'b0;

	poly1305_mac dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.push       (push),
		.full       (full),
		.block_low  (block_low),
		.block_high (block_high),
		.byte_count (byte_count),
		.last_block (last_block),
		.empty      (empty),
		.pop        (pop),
		.tag_low    (tag_low),
		.tag_high   (tag_high)
	);

	initial forever #2 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	// Tag side: check accepted tags, stall pop in random bursts
	initial begin
		int stall;
		bit rx_calm;
		stall = 0;
		rx_calm = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				tag_calc.check_tag(tag_low, tag_high);
			if ($urandom_range(0, 299) == 0)
				rx_calm = !rx_calm;
			if (stall > 0) begin
				stall--;
			end else if (!quiet && !rx_calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 19);
			end
			pop <= (stall == 0);
		end
	end

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
			0: rand_word = '1;
			1: rand_word = '0;
			default: rand_word = {$urandom, $urandom};
		endcase
	endfunction

	// Hold one request until accepted, then maybe idle the sender
	task automatic send_item(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] cnt, input logic last);
		push <= 1'b1;
		block_low <= lo;
		block_high <= hi;
		byte_count <= cnt;
		last_block <= last;
		do @(posedge clk); while (full);
		tag_calc.absorb_request(lo, hi, cnt, last);
		if (cnt != 5'd0 || last)
			items_sent++;
		if ($urandom_range(0, 199) == 0)
			tx_calm = !tx_calm;
		if (!quiet && !tx_calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Drop push and wait until every tag is out and the block has gone quiet
	task automatic settle();
		push <= 1'b0;
		while (tag_calc.tags_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one key register, then read it back
	task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tag_calc.set_key(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val)
			tag_calc.flag($sformatf("register %0d read back %h, wrote %h", idx, prdata, val));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(input logic [63:0] rl, input logic [63:0] rh,
			input logic [63:0] sl, input logic [63:0] sh);
		write_key(REG_R_LO, rl);
		write_key(REG_R_HI, rh);
		write_key(REG_S_LO, sl);
		write_key(REG_S_HI, sh);
		key_settings++;
	endtask

	// Mostly full blocks closed by a last block; some saturated counts and stray partials
	task automatic send_random_message();
		int nblk;
		nblk = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
		for (int i = 0; i < nblk; i++) begin
			case ($urandom_range(0, 19))
				0: send_item(rand_word(), rand_word(), 5'($urandom_range(17, 31)), 1'b0);
				1: send_item(rand_word(), rand_word(), 5'($urandom_range(0, 15)), 1'b0);
				default: send_item(rand_word(), rand_word(), 5'd16, 1'b0);
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			send_item(rand_word(), rand_word(), 5'($urandom_range(17, 31)), 1'b1);
		else
			send_item(rand_word(), rand_word(), 5'($urandom_range(0, 16)), 1'b1);
	endtask

	task automatic run_phase(input logic [63:0] rl, input logic [63:0] rh,
			input logic [63:0] sl, input logic [63:0] sh);
		int stop;
		settle();
		load_key(rl, rh, sl, sh);
		stop = items_sent + PHASE_ITEMS;
		while (items_sent < stop)
			send_random_message();
	endtask

	// Stimulus
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: largest key, empty message, padding edges, count saturation
		load_key('1, '1, '1, '1);
		send_item('0, '0, 5'd0, 1'b1);
		send_item('1, '1, 5'd16, 1'b0);
		send_item('1, '1, 5'd16, 1'b1);
		send_item('1, '1, 5'd1, 1'b1);
		send_item('1, '1, 5'd7, 1'b1);
		send_item('1, '1, 5'd8, 1'b1);
		send_item('1, '1, 5'd9, 1'b1);
		send_item('1, '1, 5'd15, 1'b1);
		send_item('0, '0, 5'd16, 1'b1);
		send_item(rand_word(), rand_word(), 5'd31, 1'b0);
		send_item(rand_word(), rand_word(), 5'd0, 1'b0);
		send_item(rand_word(), rand_word(), 5'd5, 1'b0);
		send_item(rand_word(), rand_word(), 5'd17, 1'b1);

		// Directed: change r halfway through a message
		send_item(rand_word(), rand_word(), 5'd16, 1'b0);
		send_item(rand_word(), rand_word(), 5'd16, 1'b0);
		settle();
		write_key(REG_R_LO, {$urandom, $urandom});
		send_item(rand_word(), rand_word(), 5'd12, 1'b1);

		// Random phases over several keys, the last one without idling
		run_phase({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		run_phase('0, '0, {$urandom, $urandom}, {$urandom, $urandom});
		run_phase('1, '1, '1, '1);
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, '0, '0);
		quiet = 1'b1;
		run_phase({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});

		push <= 1'b0;
		while (tag_calc.tags_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("run covered %0d requests (%0d blocks absorbed) under %0d key settings,",
			items_sent, tag_calc.blocks_absorbed, key_settings);
		$display("%0d tags checked, %0d mismatches", tag_calc.tags_seen, tag_calc.errors);
		if (tag_calc.errors == 0 && tag_calc.tags_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
src/pmac_pkg.sv
src/pmac_fifo.sv
src/pmac_front.sv
src/pmac_back.sv
src/poly1305_mac.sv
tb/poly1305_mac_tb.sv
